[src/assert_macros.svh]
// Assertion helpers, shared by every file that asserts
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[src/rrmqm_pkg.sv]
package rrmqm_pkg;

   localparam logic CMD_SEND = 1'b0;
   localparam logic CMD_RECV = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_LOOKUP,
      ST_SEND,
      ST_RECV,
      ST_ENTRY
   } state_type;

   typedef enum logic [1:0] {
      RSP_NONE,
      RSP_ZERO,
      RSP_SEND,
      RSP_RECV
   } rsp_sel_type;

   typedef struct packed {
      logic        load;
      logic        scan_step;
      logic        q_from_req;
      logic        q_from_scan;
      logic        send_commit;
      logic        recv_commit;
      rsp_sel_type rsp_sel;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic is_recv;
      logic hit;
      logic scan_last;
      logic full;
   } status_type;

endpackage

[src/rrmqm_ram.sv]
module rrmqm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/rrmqm_ctrl.sv]
module rrmqm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  rrmqm_pkg::status_type   status,
   output rrmqm_pkg::cmd_type      cmd
);

   import rrmqm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp_sel = RSP_NONE;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!status.in_range) begin
               cmd.rsp_sel = RSP_ZERO;
               state_in    = ST_IDLE;
            end else if (status.is_recv) begin
               state_in = ST_SCAN;
            end else begin
               cmd.q_from_req = 1'b1;
               state_in       = ST_LOOKUP;
            end
         end
         ST_SCAN: begin
            if (status.hit) begin
               cmd.q_from_scan = 1'b1;
               state_in        = ST_LOOKUP;
            end else if (status.scan_last) begin
               cmd.rsp_sel = RSP_ZERO;
               state_in    = ST_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_LOOKUP: begin
            state_in = status.is_recv ? ST_RECV : ST_SEND;
         end
         ST_SEND: begin
            cmd.send_commit = !status.full;
            cmd.rsp_sel     = RSP_SEND;
            state_in        = ST_IDLE;
         end
         ST_RECV: begin
            cmd.recv_commit = 1'b1;
            state_in        = ST_ENTRY;
         end
         ST_ENTRY: begin
            cmd.rsp_sel = RSP_RECV;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[src/rrmqm_dp.sv]
module rrmqm_dp #(
   parameter int NODES      = 4,
   parameter int FIFO_DEPTH = 16,
   parameter int ROUND_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rrmqm_pkg::cmd_type    cmd,
   output rrmqm_pkg::status_type status,
   input  logic                  req_command,
   input  logic [1:0]            req_sender,
   input  logic [1:0]            req_receiver,
   input  logic [1:0]            req_msg_type,
   input  logic [7:0]            req_msg_round,
   input  logic signed [1:0]     req_msg_value,
   input  logic                  req_msg_valid,
   output logic                  rsp_strobe,
   output logic                  rsp_accepted,
   output logic                  rsp_found,
   output logic [1:0]            rsp_out_sender,
   output logic [1:0]            rsp_out_type,
   output logic [7:0]            rsp_out_round,
   output logic signed [1:0]     rsp_out_value,
   output logic                  rsp_out_valid,
   output logic [4:0]            rsp_queue_fill
);

   import rrmqm_pkg::*;
   `include "assert_macros.svh"

   localparam int QUEUES = NODES * NODES;
   localparam int NW     = $clog2(NODES);
   localparam int QW     = $clog2(QUEUES);
   localparam int PW     = $clog2(FIFO_DEPTH);
   localparam int FW     = $clog2(FIFO_DEPTH + 1);
   localparam int AW     = $clog2(QUEUES * FIFO_DEPTH);
   localparam int RSW    = (ROUND_BITS < 8) ? ROUND_BITS : 8;
   localparam int EW     = 5 + RSW;
   localparam int QSW    = 2 * PW + FW;

   function automatic logic [QW-1:0] qidx(input logic [NW-1:0] s, input logic [NW-1:0] r);
      qidx = QW'(32'(s) * NODES + 32'(r));
   endfunction

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      ptr_inc = (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [4:0] fill5(input logic [FW-1:0] f);
      logic [31:0] w;
      w = 32'(f);
      fill5 = w[4:0];
   endfunction

   // latched request
   logic            cmd_ff;
   logic [NW-1:0]   snd_ff;
   logic [NW-1:0]   rcv_ff;
   logic [1:0]      type_ff;
   logic [RSW-1:0]  round_ff;
   logic [1:0]      value_ff;
   logic            msg_valid_ff;
   logic            in_range_ff;

   // scan and queue selection
   logic [NW-1:0]   cnt_ff;
   logic [NW-1:0]   start_ff;
   logic [NW-1:0]   who_ff;
   logic [QW-1:0]   q_ff;
   logic [FW-1:0]   fill_new_ff;
   logic [QUEUES-1:0] nonempty_ff;
   logic [QUEUES-1:0] touched_ff;

   // response
   logic            strobe_ff;
   logic            accepted_ff;
   logic            found_ff;
   logic [1:0]      sender_ff;
   logic [1:0]      type_out_ff;
   logic [7:0]      round_out_ff;
   logic [1:0]      value_out_ff;
   logic            valid_out_ff;
   logic [4:0]      fill_out_ff;

   logic [NW:0]     who_sum;
   logic [NW-1:0]   scan_who;
   logic [QSW-1:0]  qs_rdata;
   logic [QSW-1:0]  qs_cur;
   logic [QSW-1:0]  qs_wdata;
   logic [PW-1:0]   rp_cur;
   logic [PW-1:0]   wp_cur;
   logic [FW-1:0]   fill_cur;
   logic            full;
   logic [AW-1:0]   ent_waddr;
   logic [AW-1:0]   ent_raddr;
   logic [EW-1:0]   ent_wdata;
   logic [EW-1:0]   ent_rdata;

   always_comb begin
      who_sum = (NW + 1)'(start_ff) + (NW + 1)'(cnt_ff);
      if (who_sum >= (NW + 1)'(NODES)) begin
         who_sum = who_sum - (NW + 1)'(NODES);
      end
      scan_who = who_sum[NW-1:0];
   end

   // a queue never written reads as all zero
   assign qs_cur   = touched_ff[q_ff] ? qs_rdata : '0;
   assign rp_cur   = qs_cur[QSW-1 -: PW];
   assign wp_cur   = qs_cur[FW +: PW];
   assign fill_cur = qs_cur[FW-1:0];
   assign full     = (fill_cur == FW'(FIFO_DEPTH));

   assign qs_wdata = cmd.send_commit ? {rp_cur, ptr_inc(wp_cur), fill_cur + 1'b1}
                                     : {ptr_inc(rp_cur), wp_cur, fill_cur - 1'b1};

   assign ent_waddr = AW'(32'(q_ff) * FIFO_DEPTH + 32'(wp_cur));
   assign ent_raddr = AW'(32'(q_ff) * FIFO_DEPTH + 32'(rp_cur));
   assign ent_wdata = {round_ff, type_ff, value_ff, msg_valid_ff};

   assign status.in_range  = in_range_ff;
   assign status.is_recv   = (cmd_ff == CMD_RECV);
   assign status.hit       = nonempty_ff[qidx(scan_who, rcv_ff)];
   assign status.scan_last = (cnt_ff == NW'(NODES - 1));
   assign status.full      = full;

   rrmqm_ram #(
      .WIDTH (QSW),
      .DEPTH (QUEUES)
   ) u_qstate (
      .clock (clock),
      .we    (cmd.send_commit | cmd.recv_commit),
      .waddr (q_ff),
      .wdata (qs_wdata),
      .raddr (q_ff),
      .rdata (qs_rdata)
   );

   rrmqm_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUES * FIFO_DEPTH)
   ) u_entries (
      .clock (clock),
      .we    (cmd.send_commit),
      .waddr (ent_waddr),
      .wdata (ent_wdata),
      .raddr (ent_raddr),
      .rdata (ent_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff       <= req_command;
         snd_ff       <= NW'(32'(req_sender));
         rcv_ff       <= NW'(32'(req_receiver));
         type_ff      <= req_msg_type;
         round_ff     <= req_msg_round[RSW-1:0];
         value_ff     <= req_msg_value;
         msg_valid_ff <= req_msg_valid;
         in_range_ff  <= (32'(req_receiver) < NODES) &&
                         ((req_command == CMD_RECV) || (32'(req_sender) < NODES));
         cnt_ff       <= '0;
      end else if (cmd.scan_step) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.q_from_req) begin
         q_ff <= qidx(snd_ff, rcv_ff);
      end
      if (cmd.q_from_scan) begin
         q_ff   <= qidx(scan_who, rcv_ff);
         who_ff <= scan_who;
      end
      if (cmd.recv_commit) begin
         fill_new_ff <= fill_cur - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff    <= '0;
         nonempty_ff <= '0;
         touched_ff  <= '0;
      end else begin
         if (cmd.send_commit) begin
            nonempty_ff[q_ff] <= 1'b1;
            touched_ff[q_ff]  <= 1'b1;
         end
         if (cmd.recv_commit) begin
            nonempty_ff[q_ff] <= (fill_cur != FW'(1));
            touched_ff[q_ff]  <= 1'b1;
            start_ff          <= (who_ff == NW'(NODES - 1)) ? '0 : who_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= (cmd.rsp_sel != RSP_NONE);
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.rsp_sel)
         RSP_ZERO: begin
            accepted_ff  <= 1'b0;
            found_ff     <= 1'b0;
            sender_ff    <= '0;
            type_out_ff  <= '0;
            round_out_ff <= '0;
            value_out_ff <= '0;
            valid_out_ff <= 1'b0;
            fill_out_ff  <= '0;
         end
         RSP_SEND: begin
            accepted_ff  <= !full;
            found_ff     <= 1'b0;
            sender_ff    <= '0;
            type_out_ff  <= '0;
            round_out_ff <= '0;
            value_out_ff <= '0;
            valid_out_ff <= 1'b0;
            fill_out_ff  <= full ? fill5(fill_cur) : fill5(fill_cur + 1'b1);
         end
         RSP_RECV: begin
            accepted_ff  <= 1'b0;
            found_ff     <= 1'b1;
            sender_ff    <= 2'(32'(who_ff));
            type_out_ff  <= ent_rdata[4:3];
            round_out_ff <= 8'(ent_rdata[EW-1:5]);
            value_out_ff <= ent_rdata[2:1];
            valid_out_ff <= ent_rdata[0];
            fill_out_ff  <= fill5(fill_new_ff);
         end
         default: begin
         end
      endcase
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_accepted   = accepted_ff;
   assign rsp_found      = found_ff;
   assign rsp_out_sender = sender_ff;
   assign rsp_out_type   = type_out_ff;
   assign rsp_out_round  = round_out_ff;
   assign rsp_out_value  = value_out_ff;
   assign rsp_out_valid  = valid_out_ff;
   assign rsp_queue_fill = fill_out_ff;

   `ASSERT_SAME(a_no_overfill, clock, reset, cmd.send_commit, !full)
   `ASSERT_SAME(a_pop_nonempty, clock, reset, cmd.recv_commit, fill_cur != '0)
   `ASSERT_SAME(a_flag_matches_fill, clock, reset, cmd.recv_commit, nonempty_ff[q_ff])
   `ASSERT_SAME(a_rsp_exclusive, clock, reset, rsp_strobe, !(rsp_found && rsp_accepted))

endmodule

[src/round_robin_message_queue_mesh.sv]
// channel   | handshake          | ports
// ----------+--------------------+-------------------------------------------
// request   | start && !busy     | req_command, req_sender .. req_msg_valid
// response  | rsp_strobe (1 cyc) | rsp_accepted, rsp_found .. rsp_queue_fill
//
// One command at a time; the sequencer steps through the queue-state RAM and
// the message RAM, both with registered reads. Busy spans CHECK, then LOOKUP, SEND
// for a send, SCAN (1..NODES senders probed), LOOKUP, RECV, ENTRY for a pop, a full
// SCAN for a receive finding nothing, no more if out of range. The response strobes
// in the first cycle with busy low, when a new command may be taken.
// Synchronous reset clears control, flags and scan start; the receiver cannot stall.
module round_robin_message_queue_mesh #(
   parameter int NODES      = 4,
   parameter int FIFO_DEPTH = 16,
   parameter int ROUND_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_command,
   input  logic [1:0]        req_sender,
   input  logic [1:0]        req_receiver,
   input  logic [1:0]        req_msg_type,
   input  logic [7:0]        req_msg_round,
   input  logic signed [1:0] req_msg_value,
   input  logic              req_msg_valid,
   output logic              rsp_strobe,
   output logic              rsp_accepted,
   output logic              rsp_found,
   output logic [1:0]        rsp_out_sender,
   output logic [1:0]        rsp_out_type,
   output logic [7:0]        rsp_out_round,
   output logic signed [1:0] rsp_out_value,
   output logic              rsp_out_valid,
   output logic [4:0]        rsp_queue_fill
);

   import rrmqm_pkg::*;

   cmd_type    cmd;
   status_type status;

   rrmqm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   rrmqm_dp #(
      .NODES      (NODES),
      .FIFO_DEPTH (FIFO_DEPTH),
      .ROUND_BITS (ROUND_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_command    (req_command),
      .req_sender     (req_sender),
      .req_receiver   (req_receiver),
      .req_msg_type   (req_msg_type),
      .req_msg_round  (req_msg_round),
      .req_msg_value  (req_msg_value),
      .req_msg_valid  (req_msg_valid),
      .rsp_strobe     (rsp_strobe),
      .rsp_accepted   (rsp_accepted),
      .rsp_found      (rsp_found),
      .rsp_out_sender (rsp_out_sender),
      .rsp_out_type   (rsp_out_type),
      .rsp_out_round  (rsp_out_round),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_valid  (rsp_out_valid),
      .rsp_queue_fill (rsp_queue_fill)
   );

endmodule

[bench/round_robin_message_queue_mesh_tb.sv]
module round_robin_message_queue_mesh_tb;
   import rrmqm_pkg::*;

   localparam int NODES = 4;
   localparam int DEPTH = 16;
   localparam int ITEMS = 1050;

   typedef struct {
      logic              command;
      logic [1:0]        sender;
      logic [1:0]        receiver;
      logic [1:0]        mtype;
      logic [7:0]        rnd;
      logic signed [1:0] value;
      logic              valid;
      bit                hold;
   } mesh_op_type;

   typedef struct {
      logic [1:0]        mtype;
      logic [7:0]        rnd;
      logic signed [1:0] value;
      logic              valid;
   } mesh_msg_type;

   typedef struct {
      logic              accepted;
      logic              found;
      logic [1:0]        sender;
      logic [1:0]        mtype;
      logic [7:0]        rnd;
      logic signed [1:0] value;
      logic              valid;
      logic [4:0]        fill;
   } mesh_resp_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_command = CMD_SEND;
   logic [1:0]        req_sender = '0;
   logic [1:0]        req_receiver = '0;
   logic [1:0]        req_msg_type = '0;
   logic [7:0]        req_msg_round = '0;
   logic signed [1:0] req_msg_value = '0;
   logic              req_msg_valid = 1'b0;
   logic              rsp_strobe;
   logic              rsp_accepted;
   logic              rsp_found;
   logic [1:0]        rsp_out_sender;
   logic [1:0]        rsp_out_type;
   logic [7:0]        rsp_out_round;
   logic signed [1:0] rsp_out_value;
   logic              rsp_out_valid;
   logic [4:0]        rsp_queue_fill;

   mesh_op_type   pending_ops[$];
   mesh_resp_type expected_rsps[$];

   mesh_msg_type msg_ram[NODES*NODES][DEPTH];
   int        q_fill[NODES*NODES];
   int        q_rd[NODES*NODES];
   int        q_wr[NODES*NODES];
   int        rr_start = 0;

   int mismatches = 0;
   int ops_sent = 0;
   int rsp_seen = 0;
   int burst_left = 0;
   int gap_left = 0;
   int n_items = 0;

   round_robin_message_queue_mesh uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_sender(req_sender),
      .req_receiver(req_receiver),
      .req_msg_type(req_msg_type),
      .req_msg_round(req_msg_round),
      .req_msg_value(req_msg_value),
      .req_msg_valid(req_msg_valid),
      .rsp_strobe(rsp_strobe),
      .rsp_accepted(rsp_accepted),
      .rsp_found(rsp_found),
      .rsp_out_sender(rsp_out_sender),
      .rsp_out_type(rsp_out_type),
      .rsp_out_round(rsp_out_round),
      .rsp_out_value(rsp_out_value),
      .rsp_out_valid(rsp_out_valid),
      .rsp_queue_fill(rsp_queue_fill)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic mesh_resp_type forecast_response(mesh_op_type op);
      mesh_resp_type r;
      mesh_msg_type  m;
      int         q;
      int         who;
      r = '{default: '0};
      if (op.command == CMD_SEND) begin
         q = op.sender * NODES + op.receiver;
         if (q_fill[q] >= DEPTH) begin
            r.fill = 5'(q_fill[q]);
         end else begin
            m.mtype = op.mtype;
            m.rnd   = op.rnd;
            m.value = op.value;
            m.valid = op.valid;
            msg_ram[q][q_wr[q]] = m;
            q_wr[q] = (q_wr[q] + 1) % DEPTH;
            q_fill[q]++;
            r.accepted = 1'b1;
            r.fill = 5'(q_fill[q]);
         end
      end else begin
         for (int k = 0; k < NODES; k++) begin
            if (!r.found) begin
               who = (rr_start + k) % NODES;
               q = who * NODES + op.receiver;
               if (q_fill[q] != 0) begin
                  m = msg_ram[q][q_rd[q]];
                  q_rd[q] = (q_rd[q] + 1) % DEPTH;
                  q_fill[q]--;
                  rr_start = (who + 1) % NODES;
                  r.found  = 1'b1;
                  r.sender = 2'(who);
                  r.mtype  = m.mtype;
                  r.rnd    = m.rnd;
                  r.value  = m.value;
                  r.valid  = m.valid;
                  r.fill   = 5'(q_fill[q]);
               end
            end
         end
      end
      return r;
   endfunction

   task automatic check_field(string name, logic signed [31:0] expv, logic signed [31:0] actv);
      if (actv !== expv) begin
         $error("%s: expected %0d, actual %0d", name, expv, actv);
         mismatches++;
      end
   endtask

   // driver: bursts of transfers separated by random gaps
   always @(posedge clock) begin
      mesh_op_type nxt;
      bit       go;
      go = 1'b0;
      if (!reset) begin
         if (rsp_strobe) rsp_seen++;
         if (start && !busy) ops_sent++;
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_ops.size() != 0 &&
                         !(pending_ops[0].hold && ops_sent != rsp_seen)) begin
               go = 1'b1;
            end
            if (go) begin
               nxt = pending_ops.pop_front();
               req_command   <= nxt.command;
               req_sender    <= nxt.sender;
               req_receiver  <= nxt.receiver;
               req_msg_type  <= nxt.mtype;
               req_msg_round <= nxt.rnd;
               req_msg_value <= nxt.value;
               req_msg_valid <= nxt.valid;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                           : $urandom_range(1, 8);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
            start <= go;
         end
      end
   end

   // monitor: check each strobed result, then predict any transfer at this edge
   always @(posedge clock) begin
      mesh_resp_type want;
      mesh_op_type   seen;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_rsps.size() == 0) begin
               $error("response strobe with no transfer outstanding");
               mismatches++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("rsp_accepted", want.accepted, rsp_accepted);
               check_field("rsp_found", want.found, rsp_found);
               check_field("rsp_out_sender", want.sender, rsp_out_sender);
               check_field("rsp_out_type", want.mtype, rsp_out_type);
               check_field("rsp_out_round", want.rnd, rsp_out_round);
               check_field("rsp_out_value", want.value, rsp_out_value);
               check_field("rsp_out_valid", want.valid, rsp_out_valid);
               check_field("rsp_queue_fill", want.fill, rsp_queue_fill);
            end
         end
         if (start && !busy) begin
            seen.command  = req_command;
            seen.sender   = req_sender;
            seen.receiver = req_receiver;
            seen.mtype    = req_msg_type;
            seen.rnd      = req_msg_round;
            seen.value    = req_msg_value;
            seen.valid    = req_msg_valid;
            seen.hold     = 1'b0;
            expected_rsps.push_back(forecast_response(seen));
         end
      end
   end

   task automatic push_op(logic cmd, logic [1:0] snd, logic [1:0] rcv, logic [1:0] mt,
                          logic [7:0] rnd, logic [1:0] val, logic vld, bit hold);
      mesh_op_type op;
      op.command  = cmd;
      op.sender   = snd;
      op.receiver = rcv;
      op.mtype    = mt;
      op.rnd      = rnd;
      op.value    = val;
      op.valid    = vld;
      op.hold     = hold;
      pending_ops.push_back(op);
      n_items++;
   endtask

   task automatic push_random(logic cmd, logic [1:0] snd, logic [1:0] rcv, bit hold);
      push_op(cmd, snd, rcv, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
              2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), hold);
   endtask

   initial begin
      int kind;
      int len;
      int s;
      int r;
      bit hold;

      for (int q = 0; q < NODES * NODES; q++) begin
         q_fill[q] = 0;
         q_rd[q] = 0;
         q_wr[q] = 0;
      end

      // empty mesh, then one message per sender to receiver 0 and extremes
      push_op(CMD_RECV, 2'd0, 2'd0, 2'd0, 8'd0, 2'b00, 1'b0, 1'b0);
      push_op(CMD_RECV, 2'd3, 2'd3, 2'd3, 8'd255, 2'b11, 1'b1, 1'b0);
      push_op(CMD_SEND, 2'd0, 2'd0, 2'd0, 8'd0, 2'b11, 1'b0, 1'b0);
      push_op(CMD_SEND, 2'd3, 2'd3, 2'd3, 8'd255, 2'b01, 1'b1, 1'b0);
      push_op(CMD_SEND, 2'd1, 2'd0, 2'd1, 8'haa, 2'b00, 1'b1, 1'b0);
      push_op(CMD_SEND, 2'd2, 2'd0, 2'd2, 8'h55, 2'b10, 1'b0, 1'b0);
      push_op(CMD_SEND, 2'd3, 2'd0, 2'd3, 8'h0f, 2'b01, 1'b1, 1'b0);
      for (int i = 0; i < 5; i++)
         push_op(CMD_RECV, 2'(i), 2'd0, 2'd0, 8'd0, 2'b00, 1'b0, 1'b0);
      push_op(CMD_RECV, 2'd0, 2'd3, 2'd0, 8'd0, 2'b00, 1'b0, 1'b0);

      // fill one queue past full, then pop it once
      for (int i = 0; i < DEPTH + 1; i++)
         push_random(CMD_SEND, 2'd1, 2'd2, i == 0);
      push_random(CMD_RECV, 2'($urandom_range(0, 3)), 2'd2, 1'b0);

      while (n_items < ITEMS) begin
         kind = $urandom_range(0, 9);
         hold = ($urandom_range(0, 24) == 0);
         s = $urandom_range(0, NODES - 1);
         r = $urandom_range(0, NODES - 1);
         case (kind)
            0, 1: begin
               len = $urandom_range(1, 8);
               for (int i = 0; i < len; i++)
                  push_random(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                              2'($urandom_range(0, 3)), hold && i == 0);
            end
            2, 3, 4: begin
               len = $urandom_range(8, 20);
               for (int i = 0; i < len; i++)
                  push_random(CMD_SEND, 2'(s), 2'(r), hold && i == 0);
            end
            5, 6, 7: begin
               len = $urandom_range(4, 20);
               for (int i = 0; i < len; i++)
                  push_random(CMD_RECV, 2'($urandom_range(0, 3)),
                              ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : 2'(r),
                              hold && i == 0);
            end
            default: begin
               len = $urandom_range(10, 30);
               for (int i = 0; i < len; i++)
                  push_random(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), 2'(r),
                              hold && i == 0);
            end
         endcase
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || start) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
